FILE: src/fxa_pkg.sv
// Shared types, codes and helpers for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fxa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_W        = 32;

    localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_INC      = 4'd4,
        CMD_DEC      = 4'd5,
        CMD_COMPARE  = 4'd6,
        CMD_MIN      = 4'd7,
        CMD_MAX      = 4'd8,
        CMD_FROM_INT = 4'd9,
        CMD_TO_INT   = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Sideband that travels with every word through the pipeline.
    typedef struct packed {
        logic              valid;
        logic [3:0]        cmd;
        logic [WORD_W-1:0] value;
        logic [1:0]        status;
        logic              less;
        logic              equal;
        logic              neg;
        logic              div0;
    } t_side;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic [WORD_W-1:0] sat33(input logic [WORD_W:0] x);
        logic [WORD_W-1:0] r;
        if (x[WORD_W] != x[WORD_W-1]) begin
            r = x[WORD_W] ? Q_MIN : Q_MAX;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/fxa_pre.sv
// Front stages: simple operations, the product, and divider operand setup.
`timescale 1ns / 1ps
module fxa_pre #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [3:0]           i_cmd,
    input  logic signed [31:0]   i_a,
    input  logic signed [31:0]   i_b,
    output fxa_pkg::t_side       o_side,
    output logic [DW-1:0]        o_dvd,
    output logic [31:0]          o_dvs
);
    import fxa_pkg::*;

    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

    t_side               r1_side, n1_side, r2_side, n2_side;
    logic signed [63:0]  r1_prod;
    logic [DW-1:0]       r1_dvd, r2_dvd;
    logic [31:0]         r1_dvs, r2_dvs;

    logic [32:0]         a33, b33, abs_a, abs_b, ti;
    logic signed [63:0]  fi, mt;

    always_comb begin
        a33   = {i_a[31], i_a};
        b33   = {i_b[31], i_b};
        abs_a = i_a[31] ? (33'd0 - a33) : a33;
        abs_b = i_b[31] ? (33'd0 - b33) : b33;
        fi    = 64'(i_a) <<< FRAC_BITS;
        ti    = 33'($signed(a33 + (i_a[31] ? FRAC_MASK[32:0] : 33'd0)) >>> FRAC_BITS);

        n1_side        = '0;
        n1_side.valid  = i_valid;
        n1_side.cmd    = i_cmd;
        n1_side.less   = i_a < i_b;
        n1_side.equal  = i_a == i_b;
        n1_side.neg    = i_a[31] ^ i_b[31];
        n1_side.div0   = i_b == 32'sd0;
        n1_side.status = ST_OK;
        case (i_cmd)
            CMD_ADD: begin
                n1_side.value = sat33(a33 + b33);
                if (n1_side.value != 32'(a33 + b33)) n1_side.status = ST_OVF;
            end
            CMD_SUB: begin
                n1_side.value = sat33(a33 - b33);
                if (n1_side.value != 32'(a33 - b33)) n1_side.status = ST_OVF;
            end
            CMD_INC: begin
                n1_side.value = sat33(a33 + 33'd1);
                if (i_a == Q_MAX) n1_side.status = ST_OVF;
            end
            CMD_DEC: begin
                n1_side.value = sat33(a33 - 33'd1);
                if (i_a == Q_MIN) n1_side.status = ST_OVF;
            end
            CMD_MIN: n1_side.value = n1_side.less ? i_a : i_b;
            CMD_MAX: n1_side.value = (!n1_side.less && !n1_side.equal) ? i_a : i_b;
            CMD_FROM_INT: begin
                if (fi > 64'(Q_MAX)) begin
                    n1_side.value  = Q_MAX;
                    n1_side.status = ST_OVF;
                end else if (fi < 64'(Q_MIN)) begin
                    n1_side.value  = Q_MIN;
                    n1_side.status = ST_OVF;
                end else begin
                    n1_side.value = fi[31:0];
                end
            end
            CMD_TO_INT: n1_side.value = ti[31:0];
            default:    n1_side.value = '0;
        endcase
    end

    // Truncate the product toward zero, then saturate.
    always_comb begin
        mt      = (r1_prod + (r1_prod[63] ? $signed(FRAC_MASK) : 64'sd0)) >>> FRAC_BITS;
        n2_side = r1_side;
        if (r1_side.cmd == CMD_MUL) begin
            if (mt > 64'(Q_MAX)) begin
                n2_side.value  = Q_MAX;
                n2_side.status = ST_OVF;
            end else if (mt < 64'(Q_MIN)) begin
                n2_side.value  = Q_MIN;
                n2_side.status = ST_OVF;
            end else begin
                n2_side.value = mt[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
        end else begin
            r1_side <= n1_side;
            r2_side <= n2_side;
        end
        r1_prod <= 64'(i_a) * 64'(i_b);
        r1_dvd  <= {abs_a[31:0], {FRAC_BITS{1'b0}}};
        r1_dvs  <= abs_b[31:0];
        r2_dvd  <= r1_dvd;
        r2_dvs  <= r1_dvs;
    end

    assign o_side = r2_side;
    assign o_dvd  = r2_dvd;
    assign o_dvs  = r2_dvs;

endmodule

FILE: src/fxa_div.sv
// Restoring divider pipeline, one quotient bit per stage, sideband alongside.
`timescale 1ns / 1ps
module fxa_div #(
    parameter int DW = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fxa_pkg::t_side i_side,
    input  logic [DW-1:0]  i_dvd,
    input  logic [31:0]    i_dvs,
    output fxa_pkg::t_side o_side,
    output logic [DW-1:0]  o_quot
);
    import fxa_pkg::*;

    t_side         r_side [DW];
    logic [32:0]   r_rem  [DW];
    logic [DW-1:0] r_q    [DW];
    logic [31:0]   r_d    [DW];

    for (genvar k = 0; k < DW; k++) begin : g_step
        t_side         p_side;
        logic [32:0]   p_rem, n_rem, trial;
        logic [DW-1:0] p_q;
        logic [31:0]   p_d;
        logic          fits;

        if (k == 0) begin : g_first
            assign p_side = i_side;
            assign p_rem  = '0;
            assign p_q    = i_dvd;
            assign p_d    = i_dvs;
        end else begin : g_next
            assign p_side = r_side[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_q    = r_q[k-1];
            assign p_d    = r_d[k-1];
        end

        always_comb begin
            trial = {p_rem[31:0], p_q[DW-1]};
            fits  = trial >= {1'b0, p_d};
            n_rem = fits ? (trial - {1'b0, p_d}) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= p_side;
            end
            r_rem[k]  <= n_rem;
            r_q[k]    <= {p_q[DW-2:0], fits};
            r_d[k]    <= p_d;
        end
    end

    assign o_side = r_side[DW-1];
    assign o_quot = r_q[DW-1];

endmodule

FILE: src/fixed_point_q24_8_alu_top.sv
// Top level of the Q24.8 fixed-point ALU pipeline.
`timescale 1ns / 1ps
// Usage
//   Drive i_cmd, i_operand_a and i_operand_b and raise i_start; the word is
//   taken at the clock edge where i_start is high and o_busy is low. o_busy
//   stays low, so a new word may be issued every cycle.
//   Results leave on o_value, o_less, o_equal and o_status, qualified by
//   o_done for exactly one cycle, in issue order.
// Pipeline
//   Every command takes the same path from the accepting edge to the edge
//   that takes the result, one word per cycle: the divider, one quotient bit
//   per stage over 32 + FRAC_BITS stages, plus input, product,
//   product-rounding and output registers. All commands share that path so
//   results stay in order.
// Reset
//   Synchronous, active low: clears the valid bits, dropping words in flight.
// Back-pressure
//   None: the receiver must take each result in its strobe cycle.
module fixed_point_q24_8_alu_top #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [3:0]         i_cmd,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_done,
    output logic signed [31:0] o_value,
    output logic               o_less,
    output logic               o_equal,
    output logic [1:0]         o_status
);
    import fxa_pkg::*;

    localparam int DW  = 32 + FRAC_BITS;
    localparam int LAT = DW + 4;

    // Input register stage.
    logic               r0_valid;
    logic [3:0]         r0_cmd;
    logic signed [31:0] r0_a, r0_b;

    t_side         pre_side, div_side;
    logic [DW-1:0] pre_dvd, div_quot;
    logic [31:0]   pre_dvs;

    logic               r_done, n_done;
    logic signed [31:0] r_value, n_value;
    logic               r_less, r_equal;
    logic [1:0]         r_status, n_status;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_start && !o_busy;
        end
        r0_cmd   <= i_cmd;
        r0_a     <= i_operand_a;
        r0_b     <= i_operand_b;
    end

    fxa_pre #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_cmd   (r0_cmd),
        .i_a     (r0_a),
        .i_b     (r0_b),
        .o_side  (pre_side),
        .o_dvd   (pre_dvd),
        .o_dvs   (pre_dvs)
    );

    fxa_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (pre_side),
        .i_dvd   (pre_dvd),
        .i_dvs   (pre_dvs),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    // Sign the quotient, saturate and flag divide by zero; every other command passes its value.
    always_comb begin
        n_done   = div_side.valid;
        n_value  = div_side.value;
        n_status = div_side.status;
        if (div_side.cmd == CMD_DIV) begin
            if (div_side.div0) begin
                n_value  = '0;
                n_status = ST_DIV0;
            end else if (!div_side.neg && div_quot > DW'(64'h7FFF_FFFF)) begin
                n_value  = Q_MAX;
                n_status = ST_OVF;
            end else if (div_side.neg && div_quot > DW'(64'h8000_0000)) begin
                n_value  = Q_MIN;
                n_status = ST_OVF;
            end else begin
                n_value  = div_side.neg ? (32'sd0 - $signed(div_quot[31:0]))
                                        : $signed(div_quot[31:0]);
                n_status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_value  <= n_value;
        r_less   <= div_side.less;
        r_equal  <= div_side.equal;
        r_status <= n_status;
    end

    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_less   = r_less;
    assign o_equal  = r_equal;
    assign o_status = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("result strobe missing after a word was taken");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_DIV0) |-> (o_value == 32'sd0))
        else $error("divide by zero with non-zero value");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_less && o_equal))
        else $error("less and equal both set");

endmodule

FILE: sim/tb_fixed_point_q24_8_alu_top.sv
// Self-checking testbench for the Q24.8 fixed-point ALU top level.
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu_top;
    import fxa_pkg::*;

    localparam int FRAC    = 8;
    localparam int N_RAND  = 1250;
    localparam int DRAIN   = 120;   // comfortably above the pipeline latency

    // One result word as the ALU reports it.
    typedef struct {
        logic signed [31:0] value;
        logic               less;
        logic               equal;
        logic [1:0]         status;
    } t_alu_res;

    // One row of the directed table; chk marks a hand-typed expectation.
    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 chk;
        t_alu_res           res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [3:0]         i_cmd = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_busy;
    logic               o_done;
    logic signed [31:0] o_value;
    logic               o_less;
    logic               o_equal;
    logic [1:0]         o_status;

    t_alu_res pending_res[$];
    int       n_mismatch = 0;
    int       n_results = 0;
    int       n_words = 0;
    t_row     dir_tbl[0:19];

    fixed_point_q24_8_alu_top #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_done      (o_done),
        .o_value     (o_value),
        .o_less      (o_less),
        .o_equal     (o_equal),
        .o_status    (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Saturate a wide result to 32 signed bits, flagging overflow.
    function automatic longint clamp_q(input longint x, inout logic [1:0] st);
        longint r;
        r = x;
        if (x > longint'(Q_MAX)) begin
            r  = longint'(Q_MAX);
            st = ST_OVF;
        end else if (x < longint'(Q_MIN)) begin
            r  = longint'(Q_MIN);
            st = ST_OVF;
        end
        return r;
    endfunction

    // Compute the expected word for one command; SV division truncates toward zero.
    function automatic t_alu_res predict_alu(input logic [3:0] c,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_res r;
        longint   sa;
        longint   sb;
        longint   one;
        longint   v;
        logic [1:0] st;
        sa  = a;
        sb  = b;
        one = longint'(1) << FRAC;
        v   = 0;
        st  = ST_OK;
        case (c)
            CMD_ADD:      v = clamp_q(sa + sb, st);
            CMD_SUB:      v = clamp_q(sa - sb, st);
            CMD_MUL:      v = clamp_q((sa * sb) / one, st);
            CMD_DIV: begin
                if (sb == 0) begin
                    v  = 0;
                    st = ST_DIV0;
                end else begin
                    v = clamp_q((sa * one) / sb, st);
                end
            end
            CMD_INC:      v = clamp_q(sa + 1, st);
            CMD_DEC:      v = clamp_q(sa - 1, st);
            CMD_COMPARE:  v = 0;
            CMD_MIN:      v = (sa < sb) ? sa : sb;
            CMD_MAX:      v = (sa > sb) ? sa : sb;
            CMD_FROM_INT: v = clamp_q(sa * one, st);
            CMD_TO_INT:   v = sa / one;
            default:      v = 0;
        endcase
        r.value  = v[31:0];
        r.less   = (sa < sb);
        r.equal  = (sa == sb);
        r.status = st;
        return r;
    endfunction

    function automatic t_row mk_row(input logic [3:0] c, input logic signed [31:0] a,
                                    input logic signed [31:0] b, input bit chk,
                                    input logic signed [31:0] v, input logic l,
                                    input logic e, input logic [1:0] st);
        t_row r;
        r.cmd = c;
        r.a = a;
        r.b = b;
        r.chk = chk;
        r.res.value = v;
        r.res.less = l;
        r.res.equal = e;
        r.res.status = st;
        return r;
    endfunction

    // Pick an operand: fully random in four of ten draws, else bounds, zero, small or mid-range.
    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] x;
        case ($urandom_range(0, 9))
            0:       x = Q_MAX;
            1:       x = Q_MIN;
            2:       x = 32'sd0;
            3, 4:    x = $signed($urandom_range(0, 4096)) - 32'sd2048;
            5:       x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: x = $urandom;
        endcase
        return x;
    endfunction

    // Issue one word, holding start until accepted, then note its expectation.
    task automatic issue_word(input logic [3:0] c, input logic signed [31:0] a,
                              input logic signed [31:0] b, input bit chk,
                              input t_alu_res typed, input bit may_idle);
        t_alu_res exp_res;
        // Idle for a random number of cycles, about 38 in a hundred.
        while (may_idle && ($urandom_range(0, 99) < 38)) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_start     <= 1'b1;
        i_cmd       <= c;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        exp_res = chk ? typed : predict_alu(c, a, b);
        pending_res.push_back(exp_res);
        n_words++;
    endtask

    // Check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_alu_res want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_res.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result value=%h status=%0d", o_value, o_status);
            end else begin
                want = pending_res.pop_front();
                if (o_value !== want.value || o_less !== want.less ||
                    o_equal !== want.equal || o_status !== want.status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d exp v=%h l=%b e=%b s=%0d got v=%h l=%b e=%b s=%0d",
                                 n_results, want.value, want.less, want.equal, want.status,
                                 o_value, o_less, o_equal, o_status);
                end
            end
        end
    end

    // Hard stop for a hung run.
    initial begin
        #400us;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_alu_res   dummy;
        logic [3:0] c;
        logic signed [31:0] a;
        logic signed [31:0] b;
        int         drain;

        dummy = '{value: '0, less: 1'b0, equal: 1'b0, status: ST_OK};

        // Hand-typed rows: bounds, saturation, divide by zero, compare, min/max and an unused code.
        dir_tbl[0]  = mk_row(CMD_ADD, Q_MAX, 32'sd1, 1, Q_MAX, 0, 0, ST_OVF);
        dir_tbl[1]  = mk_row(CMD_SUB, Q_MIN, 32'sd1, 1, Q_MIN, 1, 0, ST_OVF);
        dir_tbl[2]  = mk_row(CMD_DIV, 32'sd256, 32'sd0, 1, 32'sd0, 0, 0, ST_DIV0);
        dir_tbl[3]  = mk_row(CMD_INC, Q_MAX, 32'sd0, 1, Q_MAX, 0, 0, ST_OVF);
        dir_tbl[4]  = mk_row(CMD_DEC, Q_MIN, 32'sd0, 1, Q_MIN, 1, 0, ST_OVF);
        dir_tbl[5]  = mk_row(CMD_COMPARE, 32'sd5, 32'sd5, 1, 32'sd0, 0, 1, ST_OK);
        dir_tbl[6]  = mk_row(CMD_MIN, Q_MIN, Q_MAX, 1, Q_MIN, 1, 0, ST_OK);
        dir_tbl[7]  = mk_row(CMD_MAX, Q_MIN, Q_MAX, 1, Q_MAX, 1, 0, ST_OK);
        dir_tbl[8]  = mk_row(CMD_FROM_INT, Q_MAX, 32'sd0, 1, Q_MAX, 0, 0, ST_OVF);
        dir_tbl[9]  = mk_row(CMD_FROM_INT, Q_MIN, 32'sd0, 1, Q_MIN, 1, 0, ST_OVF);
        dir_tbl[10] = mk_row(4'd15, 32'sd7, 32'sd3, 1, 32'sd0, 0, 0, ST_OK);
        // Predicted rows: rounding, product and divider overflow, equal operands and an unused code.
        dir_tbl[11] = mk_row(CMD_MUL, Q_MIN, Q_MIN, 0, 0, 0, 0, 0);
        dir_tbl[12] = mk_row(CMD_MUL, -32'sd384, 32'sd128, 0, 0, 0, 0, 0);
        dir_tbl[13] = mk_row(CMD_DIV, Q_MIN, -32'sd1, 0, 0, 0, 0, 0);
        dir_tbl[14] = mk_row(CMD_DIV, -32'sd1000, 32'sd768, 0, 0, 0, 0, 0);
        dir_tbl[15] = mk_row(CMD_TO_INT, -32'sd257, 32'sd0, 0, 0, 0, 0, 0);
        dir_tbl[16] = mk_row(CMD_TO_INT, Q_MIN, Q_MAX, 0, 0, 0, 0, 0);
        dir_tbl[17] = mk_row(CMD_MIN, 32'sd9, 32'sd9, 0, 0, 0, 0, 0);
        dir_tbl[18] = mk_row(CMD_MAX, -32'sd2, -32'sd2, 0, 0, 0, 0, 0);
        dir_tbl[19] = mk_row(4'd11, Q_MAX, Q_MIN, 0, 0, 0, 0, 0);

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[k])
            issue_word(dir_tbl[k].cmd, dir_tbl[k].a, dir_tbl[k].b,
                       dir_tbl[k].chk, dir_tbl[k].res, 1'b1);

        // Random words; a stretch in the middle runs back to back.
        for (int n = 0; n < N_RAND; n++) begin
            c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            a = pick_operand();
            b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
            if (c == CMD_DIV && $urandom_range(0, 9) == 0)
                b = 32'sd0;
            issue_word(c, a, b, 1'b0, dummy, !(n >= 400 && n < 650));
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        // Drain: wait for the last expectation, then a margin for strays.
        drain = 0;
        while (pending_res.size() != 0 && drain < 10000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN) @(posedge i_clk);

        if (pending_res.size() != 0) begin
            n_mismatch++;
            $display("ERROR: %0d results never arrived", pending_res.size());
        end
        $display("Covered %0d words (directed bounds, saturation, div by zero, random mix);",
                 n_words);
        $display("checked %0d results, %0d mismatches", n_results, n_mismatch);
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
